// ----- design/rrha_pkg.sv -----
package rrha_pkg;

    localparam int HW   = 8;
    localparam int IDW  = 32;
    localparam int AW   = 48;
    localparam int KW   = 2;
    localparam int CW   = 3;
    localparam int SW   = 2;
    localparam int CAPW = 5;

    localparam logic [CAPW-1:0] CAP_RESET = 5'd16;

    localparam logic [CW-1:0] CMD_INSERT       = 3'd0;
    localparam logic [CW-1:0] CMD_ERASE        = 3'd1;
    localparam logic [CW-1:0] CMD_HANDLE_OF_ID = 3'd2;
    localparam logic [CW-1:0] CMD_ADDR_OF_ID   = 3'd3;
    localparam logic [CW-1:0] CMD_ID_OF_HANDLE = 3'd4;

    localparam logic [SW-1:0] ST_OK        = 2'd0;
    localparam logic [SW-1:0] ST_FULL      = 2'd1;
    localparam logic [SW-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [CW-1:0]  command;
        logic [AW-1:0]  device_address;
        logic [KW-1:0]  address_kind;
        logic [IDW-1:0] query_id;
        logic [HW-1:0]  query_handle;
    } in_item_t;

    typedef struct packed {
        logic [SW-1:0]  status;
        logic [IDW-1:0] result_id;
        logic [HW-1:0]  result_handle;
        logic [AW-1:0]  result_address;
        logic [KW-1:0]  result_address_kind;
    } out_item_t;

    typedef struct packed {
        logic          capture;
        logic          ptr_inc;
        logic          div_step;
        logic          cand_next;
        logic          publish;
        logic [SW-1:0] res_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [CW-1:0] in_cmd;
        logic          in_handle_ok;
        logic          full;
        logic          div_need;
        logic          div_last;
        logic          cand_free;
        logic          hit;
        logic          scan_last;
        logic          out_busy;
    } ctl_stat_t;

endpackage

// ----- design/round_robin_handle_allocator_top.sv -----
// channel  direction  handshake              payload
// s_       in         s_valid / s_ready      s_data    (in_item_t)
// m_       out        m_valid / m_ready      m_data    (out_item_t)
// cfg_     in         cfg_valid / cfg_ready  cfg_data  (capacity, 5 bits)
//
// id lookups and erase: scan the slot memories, one slot memory read per cycle
// id of handle reads only the named slot; full, bad handle or unknown command go straight to the result
// insert: probes handles one at a time (at most capacity + 1), after a bit-serial
//   remainder when capacity is below the last handle given
// reset sets slot flags, counters and capacity (16) at once, no clearing pass
// a stalled result holds the controller in its final state; one item waits in m_data
module round_robin_handle_allocator_top
    import rrha_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [CAPW-1:0] cfg_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_item_t        s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_data
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    assign cfg_ready = 1'b1;

    rrha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rrha_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- design/rrha_ctrl.sv -----
module rrha_ctrl
    import rrha_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PRIME = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DIV   = 6'b001000,
        S_SRCH  = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [SW-1:0] status_reg, status_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.res_status = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    unique case (stat.in_cmd) inside
                        CMD_INSERT: begin
                            if (stat.full) begin
                                status_next = ST_FULL;
                                state_next  = S_FIN;
                            end else if (stat.div_need) begin
                                state_next = S_DIV;
                            end else begin
                                state_next = S_SRCH;
                            end
                        end
                        CMD_ERASE, CMD_HANDLE_OF_ID, CMD_ADDR_OF_ID: begin
                            state_next = S_PRIME;
                        end
                        CMD_ID_OF_HANDLE: begin
                            if (stat.in_handle_ok) begin
                                state_next = S_PRIME;
                            end else begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_FIN;
                            end
                        end
                        default: begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_FIN;
                        end
                    endcase
                end
            end
            S_PRIME: begin
                // first read of the slot memories
                cmd.ptr_inc = 1'b1;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                if (stat.hit) begin
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end else if (stat.scan_last) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FIN;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                if (stat.cand_free) begin
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end else begin
                    cmd.cand_next = 1'b1;
                end
            end
            S_FIN: begin
                if (!stat.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- design/rrha_datapath.sv -----
module rrha_datapath
    import rrha_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    input  logic [CAPW-1:0] cfg_data,
    input  in_item_t        s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_data,
    input  ctl_cmd_t        cmd,
    output ctl_stat_t       stat
);

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LCW  = $clog2(SLOTS + 1);
    localparam int DCW  = $clog2(HW);
    localparam logic [HW-1:0]   SLOTS_H  = HW'(SLOTS);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
    localparam logic [DCW-1:0]  DIV_LAST = DCW'(HW - 1);

    logic [CAPW-1:0]   capacity_reg;
    in_item_t          item_reg;
    logic [SLOTS-1:0]  slot_used_reg;
    logic [IDW-1:0]    slot_id_reg   [SLOTS];
    logic [KW+AW-1:0]  slot_addr_reg [SLOTS];
    logic [HW-1:0]     last_reg;
    logic [IDW-1:0]    counter_reg;
    logic [LCW-1:0]    live_reg;
    logic [IDXW-1:0]   ptr_reg;
    logic [IDXW-1:0]   q_idx_reg;
    logic              q_used_reg;
    logic [IDW-1:0]    q_id_reg;
    logic [KW+AW-1:0]  q_addr_reg;
    logic [HW-1:0]     hand_reg;
    logic [HW-1:0]     rem_reg, rem_next;
    logic [HW-1:0]     dvd_reg;
    logic [DCW-1:0]    div_cnt_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg, m_data_next;

    logic [HW-1:0]     eff_cap;
    logic [HW-1:0]     divisor;
    logic [HW-1:0]     shifted;
    logic [IDXW-1:0]   hand_idx;
    logic              do_insert;
    logic              do_erase;

    assign eff_cap  = (HW'(capacity_reg) > SLOTS_H) ? SLOTS_H : HW'(capacity_reg);
    assign divisor  = eff_cap + HW'(1);
    assign hand_idx = IDXW'(hand_reg - HW'(1));

    // one quotient bit per cycle, remainder stays below the divisor
    assign shifted  = {rem_reg[HW-2:0], dvd_reg[HW-1]};
    assign rem_next = (shifted >= divisor) ? (shifted - divisor) : shifted;

    assign do_insert = cmd.publish && (cmd.res_status == ST_OK)
                       && (item_reg.command == CMD_INSERT);
    assign do_erase  = cmd.publish && (cmd.res_status == ST_OK)
                       && (item_reg.command == CMD_ERASE);

    always_comb begin
        stat              = '0;
        stat.in_cmd       = s_data.command;
        stat.in_handle_ok = (s_data.query_handle != '0) && (s_data.query_handle <= SLOTS_H);
        stat.full         = (HW'(live_reg) >= eff_cap);
        // last handle above the capacity needs a true remainder
        stat.div_need     = (last_reg > eff_cap);
        stat.div_last     = (div_cnt_reg == DIV_LAST);
        stat.cand_free    = (hand_reg != '0) && !slot_used_reg[hand_idx];
        stat.hit          = q_used_reg && ((item_reg.command == CMD_ID_OF_HANDLE)
                                           || (q_id_reg == item_reg.query_id));
        stat.scan_last    = (item_reg.command == CMD_ID_OF_HANDLE) || (q_idx_reg == LAST_IDX);
        stat.out_busy     = m_valid_reg && !m_ready;
    end

    always_comb begin
        m_data_next        = '0;
        m_data_next.status = cmd.res_status;
        if (cmd.res_status == ST_OK) begin
            case (item_reg.command)
                CMD_INSERT: begin
                    m_data_next.result_id     = counter_reg;
                    m_data_next.result_handle = hand_reg;
                end
                CMD_HANDLE_OF_ID: begin
                    m_data_next.result_handle = HW'(q_idx_reg) + HW'(1);
                end
                CMD_ADDR_OF_ID: begin
                    m_data_next.result_address      = q_addr_reg[AW-1:0];
                    m_data_next.result_address_kind = q_addr_reg[KW+AW-1:AW];
                end
                CMD_ID_OF_HANDLE: begin
                    m_data_next.result_id = q_id_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg  <= CAP_RESET;
            slot_used_reg <= '0;
            last_reg      <= '0;
            counter_reg   <= IDW'(1);
            live_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                capacity_reg <= cfg_data;
            end
            if (do_insert) begin
                slot_used_reg[hand_idx] <= 1'b1;
                last_reg                <= hand_reg;
                counter_reg             <= counter_reg + IDW'(1);
                live_reg                <= live_reg + LCW'(1);
            end
            if (do_erase) begin
                slot_used_reg[q_idx_reg] <= 1'b0;
                live_reg                 <= live_reg - LCW'(1);
            end
            if (cmd.publish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg    <= s_data;
            ptr_reg     <= (s_data.command == CMD_ID_OF_HANDLE)
                           ? IDXW'(s_data.query_handle - HW'(1)) : '0;
            hand_reg    <= (last_reg == eff_cap) ? '0 : last_reg + HW'(1);
            dvd_reg     <= last_reg + HW'(1);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else begin
            if (cmd.ptr_inc && (ptr_reg != LAST_IDX)) begin
                ptr_reg <= ptr_reg + IDXW'(1);
            end
            if (cmd.div_step) begin
                rem_reg     <= rem_next;
                dvd_reg     <= {dvd_reg[HW-2:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DIV_LAST) begin
                    hand_reg <= rem_next;
                end
            end
            if (cmd.cand_next) begin
                hand_reg <= (hand_reg == eff_cap) ? '0 : hand_reg + HW'(1);
            end
        end
        if (cmd.publish) begin
            m_data_reg <= m_data_next;
        end
    end

    // slot memories, registered read at the scan pointer
    always_ff @(posedge aclk) begin
        if (do_insert) begin
            slot_id_reg[hand_idx]   <= counter_reg;
            slot_addr_reg[hand_idx] <= {item_reg.address_kind, item_reg.device_address};
        end
        if (cmd.ptr_inc) begin
            q_id_reg   <= slot_id_reg[ptr_reg];
            q_addr_reg <= slot_addr_reg[ptr_reg];
            q_used_reg <= slot_used_reg[ptr_reg];
            q_idx_reg  <= ptr_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_live_count : assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(slot_used_reg) == 32'(live_reg))
        else $error("live count out of step with slot flags");

    a_publish_free : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> !stat.out_busy)
        else $error("result overwrote a waiting item");

    a_insert_free : assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |-> (hand_reg != '0) && (hand_reg <= eff_cap) && !slot_used_reg[hand_idx])
        else $error("insert into a used or out of range slot");

    a_div_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && stat.div_last) |=> (hand_reg <= eff_cap))
        else $error("wrapped handle above capacity");

endmodule

// ----- tb/tb_round_robin_handle_allocator_top.sv -----
module tb_round_robin_handle_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rrha_pkg::*;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 500000;
    // longest item: insert with every handle probed plus the serial remainder
    localparam int SETTLE_CYCLES = 40;
    localparam int SEGMENT_ITEMS = 106;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [CAPW-1:0] cfg_data = '0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    in_item_t        s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    out_item_t       m_data;

    // shadow copy of the handle table
    logic            live_flag [SLOTS];
    logic [IDW-1:0]  stored_id [SLOTS];
    logic [AW-1:0]   stored_addr [SLOTS];
    logic [KW-1:0]   stored_kind [SLOTS];
    int unsigned     prev_handle;
    logic [IDW-1:0]  id_counter;
    int unsigned     live_total;
    logic [CAPW-1:0] cap_setting;

    out_item_t   pending_responses [$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_hold_left = 0;

    always #5 aclk = ~aclk;

    round_robin_handle_allocator_top #(
        .SLOTS(SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // lowest live handle holding the id, 0 when none
    function automatic int unsigned handle_of(input logic [IDW-1:0] id);
        for (int i = 0; i < SLOTS; i++) begin
            if (live_flag[i] && stored_id[i] == id) begin
                return i + 1;
            end
        end
        return 0;
    endfunction

    function automatic out_item_t table_response(input in_item_t req);
        out_item_t   rsp;
        int unsigned eff;
        int unsigned h;
        int unsigned hit;
        int unsigned probes;
        rsp = '0;
        rsp.status = ST_NOT_FOUND;
        eff = (cap_setting < SLOTS) ? cap_setting : SLOTS;
        case (req.command)
            CMD_INSERT: begin
                if (live_total >= eff) begin
                    rsp.status = ST_FULL;
                end else begin
                    h = prev_handle;
                    probes = 0;
                    do begin
                        h = ((h + 1) & 8'hFF) % (eff + 1);
                        probes++;
                    end while ((h == 0 || h > SLOTS || live_flag[h-1]) && probes < 512);
                    if (h == 0 || h > SLOTS || live_flag[h-1]) begin
                        rsp.status = ST_FULL;
                    end else begin
                        prev_handle = h;
                        live_flag[h-1] = 1'b1;
                        stored_id[h-1] = id_counter;
                        stored_addr[h-1] = req.device_address;
                        stored_kind[h-1] = req.address_kind;
                        live_total++;
                        rsp.result_id = id_counter;
                        rsp.result_handle = 8'(h);
                        id_counter = id_counter + 32'd1;
                        rsp.status = ST_OK;
                    end
                end
            end
            CMD_ERASE: begin
                hit = handle_of(req.query_id);
                if (hit != 0) begin
                    live_flag[hit-1] = 1'b0;
                    live_total--;
                    rsp.status = ST_OK;
                end
            end
            CMD_HANDLE_OF_ID: begin
                hit = handle_of(req.query_id);
                if (hit != 0) begin
                    rsp.result_handle = 8'(hit);
                    rsp.status = ST_OK;
                end
            end
            CMD_ADDR_OF_ID: begin
                hit = handle_of(req.query_id);
                if (hit != 0) begin
                    rsp.result_address = stored_addr[hit-1];
                    rsp.result_address_kind = stored_kind[hit-1];
                    rsp.status = ST_OK;
                end
            end
            CMD_ID_OF_HANDLE: begin
                if (req.query_handle != 0 && req.query_handle <= SLOTS
                        && live_flag[req.query_handle-1]) begin
                    rsp.result_id = stored_id[req.query_handle-1];
                    rsp.status = ST_OK;
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic in_item_t make_request(input logic [CW-1:0] cmd,
                                              input logic [AW-1:0] addr,
                                              input logic [KW-1:0] kind,
                                              input logic [IDW-1:0] qid,
                                              input logic [HW-1:0] qh);
        in_item_t req;
        req.command = cmd;
        req.device_address = addr;
        req.address_kind = kind;
        req.query_id = qid;
        req.query_handle = qh;
        return req;
    endfunction

    function automatic logic [IDW-1:0] some_live_id();
        int unsigned picks [$];
        for (int i = 0; i < SLOTS; i++) begin
            if (live_flag[i]) begin
                picks.push_back(i);
            end
        end
        if (picks.size() == 0) begin
            return $urandom;
        end
        return stored_id[picks[$urandom_range(picks.size() - 1, 0)]];
    endfunction

    function automatic in_item_t random_request();
        in_item_t    req;
        int unsigned roll;
        req.device_address = {16'($urandom), 32'($urandom)};
        req.address_kind = 2'($urandom);
        req.query_id = $urandom;
        req.query_handle = 8'($urandom);
        roll = $urandom_range(99, 0);
        if (roll < 35) begin
            req.command = CMD_INSERT;
        end else if (roll < 58) begin
            req.command = CMD_ERASE;
        end else if (roll < 72) begin
            req.command = CMD_HANDLE_OF_ID;
        end else if (roll < 86) begin
            req.command = CMD_ADDR_OF_ID;
        end else if (roll < 97) begin
            req.command = CMD_ID_OF_HANDLE;
        end else begin
            req.command = 3'($urandom_range(7, 5));
        end
        // mostly live ids, some stale or not yet given, rest fully random
        roll = $urandom_range(99, 0);
        if (roll < 80) begin
            req.query_id = some_live_id();
        end else if (roll < 90) begin
            req.query_id = id_counter - 32'($urandom_range(3, 0));
        end
        if ($urandom_range(99, 0) < 85) begin
            req.query_handle = 8'($urandom_range(SLOTS + 1, 0));
        end
        return req;
    endfunction

    task automatic send_item(input in_item_t req);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99, 0) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        pending_responses.push_back(table_response(req));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_responses.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAPW-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cap_setting = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        send_item(make_request(CMD_INSERT, '0, '0, '0, '0));
        send_item(make_request(CMD_INSERT, '1, '1, '1, '1));
        send_item(make_request(CMD_HANDLE_OF_ID, '1, '1, 32'd1, '1));
        send_item(make_request(CMD_ADDR_OF_ID, '0, '0, 32'd2, '0));
        send_item(make_request(CMD_ID_OF_HANDLE, '1, '1, '1, 8'd2));
        send_item(make_request(CMD_ID_OF_HANDLE, '0, '0, '0, 8'd0));
        send_item(make_request(CMD_ID_OF_HANDLE, '0, '0, '0, 8'd255));
        send_item(make_request(CMD_ID_OF_HANDLE, '0, '0, '0, 8'(SLOTS + 1)));
        send_item(make_request(CMD_ERASE, '0, '0, 32'd1, '0));
        // erase of an id that is gone
        send_item(make_request(CMD_ERASE, '0, '0, 32'd1, '0));
        send_item(make_request(CMD_ADDR_OF_ID, '0, '0, 32'd1, '0));
        send_item(make_request(CMD_HANDLE_OF_ID, '0, '0, '1, '0));
        for (int c = 5; c < 8; c++) begin
            send_item(make_request(3'(c), '1, '1, 32'd2, 8'd2));
        end
        send_item(make_request(CMD_INSERT, 48'h5A5A_0000_A5A5, 2'd1, '0, '0));
    endtask

    task automatic test_capacity_edges();
        set_capacity('0);
        send_item(make_request(CMD_INSERT, 48'h1234, 2'd2, '0, '0));
        // handles 2 and 3 stay live above the lowered capacity
        set_capacity(5'd1);
        send_item(make_request(CMD_INSERT, 48'h1234, 2'd2, '0, '0));
        send_item(make_request(CMD_ID_OF_HANDLE, '0, '0, '0, 8'd3));
        send_item(make_request(CMD_ERASE, '0, '0, 32'd2, '0));
        send_item(make_request(CMD_ERASE, '0, '0, 32'd3, '0));
        send_item(make_request(CMD_INSERT, 48'hFFFF_0000_FFFF, 2'd3, '0, '0));
        send_item(make_request(CMD_INSERT, 48'h1, 2'd0, '0, '0));
        set_capacity('1);
        send_item(make_request(CMD_INSERT, 48'h8000_0000_0001, 2'd1, '0, '0));
    endtask

    task automatic test_output_stall();
        set_capacity(CAP_RESET);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_left = 400;
        for (int n = 0; n < 40; n++) begin
            send_item(random_request());
        end
    endtask

    task automatic test_random_traffic();
        int tx_pct [4] = '{0, 74, 0, 13};
        int rx_pct [4] = '{0, 0, 74, 13};
        int k;
        for (int p = 0; p < 4; p++) begin
            for (int seg = 0; seg < 4; seg++) begin
                k = p * 4 + seg;
                tx_idle_pct = tx_pct[p];
                rx_stall_pct = rx_pct[p];
                case (k)
                    0:       set_capacity(CAP_RESET);
                    1:       set_capacity('1);
                    2:       set_capacity('0);
                    3:       set_capacity(5'd1);
                    4:       set_capacity(5'(SLOTS));
                    default: set_capacity(5'($urandom_range(31, 0)));
                endcase
                for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                    send_item(random_request());
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_item_t exp_rsp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result item: %p", m_data);
                end
            end else begin
                exp_rsp = pending_responses.pop_front();
                if (m_data.status !== exp_rsp.status
                        || m_data.result_id !== exp_rsp.result_id
                        || m_data.result_handle !== exp_rsp.result_handle
                        || m_data.result_address !== exp_rsp.result_address
                        || m_data.result_address_kind !== exp_rsp.result_address_kind) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected status %0d id %0h handle %0d addr %0h kind %0d",
                                 exp_rsp.status, exp_rsp.result_id, exp_rsp.result_handle,
                                 exp_rsp.result_address, exp_rsp.result_address_kind);
                        $display("          actual   status %0d id %0h handle %0d addr %0h kind %0d",
                                 m_data.status, m_data.result_id, m_data.result_handle,
                                 m_data.result_address, m_data.result_address_kind);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_responses.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            live_flag[i] = 1'b0;
            stored_id[i] = '0;
            stored_addr[i] = '0;
            stored_kind[i] = '0;
        end
        prev_handle = 0;
        id_counter = 32'd1;
        live_total = 0;
        cap_setting = CAP_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_capacity_edges();
        test_output_stall();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rrha_pkg.sv
design/rrha_ctrl.sv
design/rrha_datapath.sv
design/round_robin_handle_allocator_top.sv
tb/tb_round_robin_handle_allocator_top.sv
